// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the HSV to RGB converter.
// No dependencies; each macro checks one clocked implication under reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Types and constants of the HSV to RGB converter.
// No dependencies; used by the channel scaler and the top level.
package hsv2rgb_pkg;

    localparam int IN_W = 17;
    localparam int CH_W = 8;
    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    typedef logic [2:0] t_sect;

    localparam t_sect SECT_RY = 3'd0;
    localparam t_sect SECT_YG = 3'd1;
    localparam t_sect SECT_GC = 3'd2;
    localparam t_sect SECT_CB = 3'd3;
    localparam t_sect SECT_BM = 3'd4;
    localparam t_sect SECT_MR = 3'd5;

endpackage

// ===== hw/rtl/hsv2rgb_chan.sv =====
// Channel scaler: adds the offset, scales by 255, truncates and clamps to 8 bits;
// forces zero on i_err. Depends on hsv2rgb_pkg for the channel width and limit.
module hsv2rgb_chan
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic [FRAC_BITS:0] i_part,
    input  logic [FRAC_BITS:0] i_offset,
    input  logic               i_err,
    output logic [CH_W-1:0]    o_chan
);

    localparam int VW  = FRAC_BITS + 1;
    localparam int SCW = VW + CH_W;

    logic [VW-1:0]  sum;
    logic [SCW-1:0] scaled;
    logic [CH_W:0]  q;

    assign sum    = i_part + i_offset;
    assign scaled = (SCW'(sum) << CH_W) - SCW'(sum);
    assign q      = scaled[FRAC_BITS +: CH_W+1];

    always_comb begin
        if (i_err) begin
            o_chan = '0;
        end else if (q[CH_W]) begin
            o_chan = CH_MAX;
        end else begin
            o_chan = q[CH_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_core.sv =====
// HSV to RGB converter, three-stage pipeline: an accepted beat passes the stage A,
// stage B and output registers to its result strobe, throughput one beat per cycle.
// The stage depth is set by one multiplier per stage: value times saturation,
// chroma times ramp, then the three 255 scalers. busy is always low.
// Synchronous active-low reset clears the valid bits; data registers are not reset.
// Depends on hsv2rgb_pkg, hsv2rgb_chan and assert_macros.svh.
`include "assert_macros.svh"

module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [IN_W-1:0] i_hue_in,
    input  logic [IN_W-1:0] i_saturation_in,
    input  logic [IN_W-1:0] i_brightness_in,
    output logic            o_valid,
    output logic [CH_W-1:0] o_red_out,
    output logic [CH_W-1:0] o_green_out,
    output logic [CH_W-1:0] o_blue_out,
    output logic            o_range_error
);

    localparam int VW = FRAC_BITS + 1;
    localparam int CW = (IN_W > FRAC_BITS + 2) ? IN_W : FRAC_BITS + 2;
    localparam int SW = VW + 3;
    localparam int PW = 2 * VW;
    localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

    logic            accept;
    logic [CW-1:0]   hue_ext;
    logic [CW-1:0]   sat_ext;
    logic [CW-1:0]   val_ext;
    logic [VW-1:0]   hue_v;
    logic [VW-1:0]   sat_v;
    logic [VW-1:0]   val_v;
    logic [PW-1:0]   prod_vs;

    logic            r_a_valid;
    logic            r_a_err;
    logic [SW-1:0]   r_a_sector;
    logic [VW-1:0]   r_a_chroma;
    logic [VW-1:0]   r_a_val;

    t_sect           a_idx;
    logic [FRAC_BITS-1:0] a_frac;
    logic [VW-1:0]   a_ramp;
    logic [PW-1:0]   prod_ct;

    logic            r_b_valid;
    logic            r_b_err;
    t_sect           r_b_idx;
    logic [VW-1:0]   r_b_chroma;
    logic [VW-1:0]   r_b_x;
    logic [VW-1:0]   r_b_offset;

    logic [VW-1:0]   part_r;
    logic [VW-1:0]   part_g;
    logic [VW-1:0]   part_b;
    logic [CH_W-1:0] n_red;
    logic [CH_W-1:0] n_green;
    logic [CH_W-1:0] n_blue;

    logic            r_valid;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;
    logic            r_err;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign hue_ext = CW'(i_hue_in);
    assign sat_ext = CW'(i_saturation_in);
    assign val_ext = CW'(i_brightness_in);
    assign hue_v   = VW'(hue_ext);
    assign sat_v   = VW'(sat_ext);
    assign val_v   = VW'(val_ext);
    assign prod_vs = PW'(val_v) * PW'(sat_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_valid   <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_err    <= (hue_ext > ONE_C) || (sat_ext > ONE_C) || (val_ext > ONE_C);
        r_a_sector <= (SW'(hue_v) << 2) + (SW'(hue_v) << 1);
        r_a_chroma <= prod_vs[FRAC_BITS +: VW];
        r_a_val    <= val_v;
    end

    assign a_idx  = r_a_sector[FRAC_BITS +: 3];
    assign a_frac = r_a_sector[FRAC_BITS-1:0];
    assign a_ramp = a_idx[0] ? (ONE_V - VW'(a_frac)) : VW'(a_frac);
    assign prod_ct = PW'(r_a_chroma) * PW'(a_ramp);

    always_ff @(posedge i_clk) begin
        r_b_err    <= r_a_err || (a_idx > SECT_MR);
        r_b_idx    <= a_idx;
        r_b_chroma <= r_a_chroma;
        r_b_x      <= prod_ct[FRAC_BITS +: VW];
        r_b_offset <= r_a_val - r_a_chroma;
    end

    always_comb begin
        case (r_b_idx)
            SECT_RY: begin
                part_r = r_b_chroma; part_g = r_b_x;      part_b = '0;
            end
            SECT_YG: begin
                part_r = r_b_x;      part_g = r_b_chroma; part_b = '0;
            end
            SECT_GC: begin
                part_r = '0;         part_g = r_b_chroma; part_b = r_b_x;
            end
            SECT_CB: begin
                part_r = '0;         part_g = r_b_x;      part_b = r_b_chroma;
            end
            SECT_BM: begin
                part_r = r_b_x;      part_g = '0;         part_b = r_b_chroma;
            end
            default: begin
                part_r = r_b_chroma; part_g = '0;         part_b = r_b_x;
            end
        endcase
    end

    hsv2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_r (
        .i_part   (part_r),
        .i_offset (r_b_offset),
        .i_err    (r_b_err),
        .o_chan   (n_red)
    );

    hsv2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_g (
        .i_part   (part_g),
        .i_offset (r_b_offset),
        .i_err    (r_b_err),
        .o_chan   (n_green)
    );

    hsv2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_b (
        .i_part   (part_b),
        .i_offset (r_b_offset),
        .i_err    (r_b_err),
        .o_chan   (n_blue)
    );

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_err   <= r_b_err;
    end

    assign o_valid       = r_valid;
    assign o_red_out     = r_red;
    assign o_green_out   = r_green;
    assign o_blue_out    = r_blue;
    assign o_range_error = r_err;

    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, accept, r_a_valid)
    `ASSERT_IMPL(a_result_latency, i_clk, i_rst_n, o_valid, $past(start, 3))
    `ASSERT_IMPL(a_sector_ok, i_clk, i_rst_n, r_b_valid && !r_b_err, r_b_idx <= SECT_MR)
    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_range_error,
                 (o_red_out == '0) && (o_green_out == '0) && (o_blue_out == '0))

endmodule

// ===== tb/tb_hsv_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hsv_to_rgb_converter_core: directed corners, then random HSV beats.
// A local fixed-point predictor checks every result strobe; depends on hsv2rgb_pkg and the RTL.
module tb_hsv_to_rgb_converter_core;
    import hsv2rgb_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int unsigned ONE = 1 << FRAC_BITS;
    localparam int unsigned IN_MAX = (1 << IN_W) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            range_err;
    } t_rgb_beat;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [IN_W-1:0] i_hue_in;
    logic [IN_W-1:0] i_saturation_in;
    logic [IN_W-1:0] i_brightness_in;
    logic            o_valid;
    logic [CH_W-1:0] o_red_out;
    logic [CH_W-1:0] o_green_out;
    logic [CH_W-1:0] o_blue_out;
    logic            o_range_error;

    t_rgb_beat rgb_expected_q[$];
    int        n_mismatch = 0;
    int        n_beats = 0;
    int        n_results = 0;
    int        n_flagged = 0;
    int        stall_cycles = 0;
    int        idle_pct = 27;

    hsv_to_rgb_converter_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_hue_in       (i_hue_in),
        .i_saturation_in(i_saturation_in),
        .i_brightness_in(i_brightness_in),
        .o_valid        (o_valid),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_range_error  (o_range_error)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [CH_W-1:0] scale_channel(input logic [63:0] p, input logic [63:0] m);
        logic [63:0] q;
        q = ((p + m) * 64'd255) >> FRAC_BITS;
        return (q > 64'd255) ? CH_MAX : q[CH_W-1:0];
    endfunction

    function automatic t_rgb_beat hsv_to_rgb_predict(input logic [IN_W-1:0] h,
                                                     input logic [IN_W-1:0] s,
                                                     input logic [IN_W-1:0] v);
        logic [63:0] sector, idx, f2, ramp, chroma, x, m, rp, gp, bp;
        t_rgb_beat   r;
        r = '0;
        if (h > ONE || s > ONE || v > ONE) begin
            r.range_err = 1'b1;
            return r;
        end
        sector = 64'(h) * 64'd6;
        idx = sector >> FRAC_BITS;
        if (idx > 64'd5) begin
            r.range_err = 1'b1;
            return r;
        end
        f2 = sector - ((idx & ~64'd1) << FRAC_BITS);
        ramp = (f2 >= 64'(ONE)) ? (64'(2 * ONE) - f2) : f2;
        chroma = (64'(v) * 64'(s)) >> FRAC_BITS;
        x = (chroma * ramp) >> FRAC_BITS;
        m = 64'(v) - chroma;
        case (t_sect'(idx[2:0]))
            SECT_RY: begin rp = chroma; gp = x;      bp = '0;     end
            SECT_YG: begin rp = x;      gp = chroma; bp = '0;     end
            SECT_GC: begin rp = '0;     gp = chroma; bp = x;      end
            SECT_CB: begin rp = '0;     gp = x;      bp = chroma; end
            SECT_BM: begin rp = x;      gp = '0;     bp = chroma; end
            default: begin rp = chroma; gp = '0;     bp = x;      end
        endcase
        r.red = scale_channel(rp, m);
        r.green = scale_channel(gp, m);
        r.blue = scale_channel(bp, m);
        return r;
    endfunction

    function automatic logic [IN_W-1:0] noisy_field();
        case ($urandom_range(3))
            0: return IN_W'($urandom_range(IN_MAX, ONE + 1));
            1: return IN_W'($urandom);
            2: return IN_W'($urandom_range(ONE));
            default: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return IN_W'(ONE);
                    2: return IN_W'(ONE + 1);
                    default: return IN_W'(IN_MAX);
                endcase
            end
        endcase
    endfunction

    function automatic logic [IN_W-1:0] unit_field();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(1) ? IN_W'(ONE) : '0;
        end
        return IN_W'($urandom_range(ONE));
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
        n_mismatch++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_rgb_beat want;
        logic      progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                progress = 1'b1;
                n_results++;
                if (rgb_expected_q.size() == 0) begin
                    report_mismatch("result strobe with no pending beat", 0, 1);
                end else begin
                    want = rgb_expected_q.pop_front();
                    if (want.range_err) n_flagged++;
                    if (o_red_out !== want.red)
                        report_mismatch("red_out", want.red, o_red_out);
                    if (o_green_out !== want.green)
                        report_mismatch("green_out", want.green, o_green_out);
                    if (o_blue_out !== want.blue)
                        report_mismatch("blue_out", want.blue, o_blue_out);
                    if (o_range_error !== want.range_err)
                        report_mismatch("range_error", want.range_err, o_range_error);
                end
            end
            if (start && busy === 1'b0) begin
                progress = 1'b1;
                n_beats++;
                rgb_expected_q.push_back(
                    hsv_to_rgb_predict(i_hue_in, i_saturation_in, i_brightness_in));
            end
        end
        stall_cycles = progress ? 0 : stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, stall_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_beat(input logic [IN_W-1:0] h, input logic [IN_W-1:0] s,
                             input logic [IN_W-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_hue_in <= h;
        i_saturation_in <= s;
        i_brightness_in <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (rgb_expected_q.size() > 0);
    endtask

    task automatic test_directed();
        send_beat('0, '0, '0);
        send_beat(IN_W'(ONE - 1), IN_W'(ONE), IN_W'(ONE));
        send_beat('0, IN_W'(ONE), IN_W'(ONE));
        send_beat('0, '0, IN_W'(ONE));
        send_beat(IN_W'(10922), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(10923), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(21845), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(21846), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(32768), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(43690), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(43691), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(54613), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(54614), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(ONE - 1), IN_W'(ONE - 1), IN_W'(ONE - 1));
        send_beat(IN_W'(ONE), IN_W'(ONE), IN_W'(ONE));
        send_beat(IN_W'(ONE), '0, '0);
        send_beat(IN_W'(ONE + 1), '0, '0);
        send_beat('0, IN_W'(ONE + 1), '0);
        send_beat('0, '0, IN_W'(ONE + 1));
        send_beat(IN_W'(IN_MAX), IN_W'(IN_MAX), IN_W'(IN_MAX));
        send_beat(IN_W'(32768), IN_W'(32768), IN_W'(32768));
        send_beat(IN_W'(1), IN_W'(1), IN_W'(1));
    endtask

    task automatic test_random_mix(input int count);
        logic [IN_W-1:0] h, s, v;
        for (int i = 0; i < count; i++) begin
            h = IN_W'($urandom_range(ONE - 1));
            s = unit_field();
            v = unit_field();
            if ($urandom_range(99) < 20) begin
                if ($urandom_range(1)) h = noisy_field();
                if ($urandom_range(1)) s = noisy_field();
                if ($urandom_range(1)) v = noisy_field();
            end
            send_beat(h, s, v);
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_pct = 0;
        test_random_mix(count);
        idle_pct = 27;
    endtask

    task automatic test_drain_pauses(input int rounds, input int count);
        for (int r = 0; r < rounds; r++) begin
            test_random_mix(count);
            wait_for_results();
        end
    endtask

    task automatic test_out_of_range(input int count);
        for (int i = 0; i < count; i++) begin
            send_beat(noisy_field(), noisy_field(), noisy_field());
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_hue_in <= '0;
        i_saturation_in <= '0;
        i_brightness_in <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(1000);
        test_back_to_back(400);
        test_drain_pauses(3, 60);
        test_out_of_range(60);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rgb_expected_q.size() > 0)
            report_mismatch("beats still waiting for a result", 0, rgb_expected_q.size());

        $display("Ran %0d HSV beats through the converter, %0d results checked.",
                 n_beats, n_results);
        $display("%0d results were range errors; %0d mismatches.", n_flagged, n_mismatch);
        if (n_mismatch == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_chan.sv
hw/rtl/hsv_to_rgb_converter_core.sv
tb/tb_hsv_to_rgb_converter_core.sv
